>>> sv/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the 1-Wire bus master slot timing block.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

  // Field widths
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TickW   = 10;
  localparam int unsigned CountW  = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 10;

  // Stream widths, rounded up to whole bytes
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // Command codes carried on the input tuser
  localparam logic [FuncW-1:0] FN_TICK  = 3'd0;
  localparam logic [FuncW-1:0] FN_RESET = 3'd1;
  localparam logic [FuncW-1:0] FN_WBIT  = 3'd2;
  localparam logic [FuncW-1:0] FN_RBIT  = 3'd3;
  localparam logic [FuncW-1:0] FN_WBYTE = 3'd4;
  localparam logic [FuncW-1:0] FN_RBYTE = 3'd5;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_PRES_SAMP   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_SLOT_LONG   = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_SLOT_SHORT  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_READ_SAMPLE = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_READ_RECOV  = 3'd5;

  // Register reset values
  localparam logic [TickW-1:0]  RESET_LOW_DEF   = 10'd96;
  localparam logic [CountW-1:0] PRES_SAMP_DEF   = 8'd95;
  localparam logic [CountW-1:0] SLOT_LONG_DEF   = 8'd13;
  localparam logic [CountW-1:0] SLOT_SHORT_DEF  = 8'd1;
  localparam logic [CountW-1:0] READ_SAMPLE_DEF = 8'd2;
  localparam logic [CountW-1:0] READ_RECOV_DEF  = 8'd8;

  // Slot sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LOW    = 3'd1,
    PH_HIGH   = 3'd2,
    PH_WAIT   = 3'd3,
    PH_SAMPLE = 3'd4,
    PH_RECOV  = 3'd5
  } phase_t;

  // Timing configuration as seen by the sequencer
  typedef struct packed {
    logic [TickW-1:0]  reset_low_ticks;
    logic [CountW-1:0] presence_samples;
    logic [CountW-1:0] slot_long_ticks;
    logic [CountW-1:0] slot_short_ticks;
    logic [CountW-1:0] read_sample_ticks;
    logic [CountW-1:0] read_recovery_ticks;
  } cfg_t;

  // One input word after unpacking
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] data_byte;
    logic             line_level;
  } item_t;

  // One result word
  typedef struct packed {
    logic             rejected;
    logic [ByteW-1:0] read_value;
    logic             presence;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } result_t;

endpackage

`default_nettype wire

>>> sv/owm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [owm_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [owm_pkg::CfgDataW-1:0]  cfg_wdata,
  output owm_pkg::cfg_t                      cfg
);
  import owm_pkg::*;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= RESET_LOW_DEF;
      cfg.presence_samples    <= PRES_SAMP_DEF;
      cfg.slot_long_ticks     <= SLOT_LONG_DEF;
      cfg.slot_short_ticks    <= SLOT_SHORT_DEF;
      cfg.read_sample_ticks   <= READ_SAMPLE_DEF;
      cfg.read_recovery_ticks <= READ_RECOV_DEF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RESET_LOW:   cfg.reset_low_ticks     <= cfg_wdata[TickW-1:0];
        REG_PRES_SAMP:   cfg.presence_samples    <= cfg_wdata[CountW-1:0];
        REG_SLOT_LONG:   cfg.slot_long_ticks     <= cfg_wdata[CountW-1:0];
        REG_SLOT_SHORT:  cfg.slot_short_ticks    <= cfg_wdata[CountW-1:0];
        REG_READ_SAMPLE: cfg.read_sample_ticks   <= cfg_wdata[CountW-1:0];
        REG_READ_RECOV:  cfg.read_recovery_ticks <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/owm_slot_engine.sv
// ----------------------------------------------------------------------------
// owm_slot_engine
// Slot sequencer state and its single-pass update for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_slot_engine (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  owm_pkg::item_t   item,
  input  owm_pkg::cfg_t    cfg,
  output owm_pkg::result_t result
);
  import owm_pkg::*;

  phase_t               phase, phase_next;
  logic [FuncW-1:0]     operation, operation_next;
  logic [TickW-1:0]     tick_count, tick_count_next;
  logic [CountW-1:0]    sample_count, sample_count_next;
  logic [BitIdxW-1:0]   bit_index, bit_index_next;
  logic [ByteW-1:0]     shift_data, shift_data_next;
  logic                 presence_seen, presence_seen_next;
  logic                 done, rej;

  logic                 expire;
  logic                 is_write, is_byte, cur_bit, nxt_bit;
  logic [BitIdxW-1:0]   bit_inc;
  logic [CountW-1:0]    pres_limit;
  logic [TickW-1:0]     short_t, long_t, rsamp_t, rrecov_t;

  // Shared helpers for the update.
  always_comb begin
    expire     = (tick_count <= TickW'(1));
    is_write   = (operation == FN_WBIT) || (operation == FN_WBYTE);
    is_byte    = (operation == FN_WBYTE) || (operation == FN_RBYTE);
    bit_inc    = bit_index + BitIdxW'(1);
    cur_bit    = shift_data[bit_index];
    nxt_bit    = shift_data[bit_inc];
    pres_limit = (cfg.presence_samples == '0) ? CountW'(1) : cfg.presence_samples;
    short_t    = TickW'(cfg.slot_short_ticks);
    long_t     = TickW'(cfg.slot_long_ticks);
    rsamp_t    = TickW'(cfg.read_sample_ticks);
    rrecov_t   = TickW'(cfg.read_recovery_ticks);
  end

  // Next state for the current word.
  always_comb begin
    phase_next         = phase;
    operation_next     = operation;
    tick_count_next    = tick_count;
    sample_count_next  = sample_count;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    presence_seen_next = presence_seen;
    done               = 1'b0;
    rej                = 1'b0;

    if (item.func == FN_TICK) begin
      unique case (phase)
        PH_IDLE: ;
        PH_LOW: begin
          if (!expire) begin
            tick_count_next = tick_count - TickW'(1);
          end else if (operation == FN_RESET) begin
            phase_next      = PH_WAIT;
            tick_count_next = TickW'(1);
          end else if (is_write) begin
            phase_next      = PH_HIGH;
            tick_count_next = cur_bit ? long_t : short_t;
          end else begin
            phase_next      = PH_WAIT;
            tick_count_next = rsamp_t;
          end
        end
        PH_HIGH, PH_RECOV: begin
          if (!expire) begin
            tick_count_next = tick_count - TickW'(1);
          end else if (is_byte && (bit_index != '1)) begin
            // Next bit of a byte starts a fresh slot.
            bit_index_next  = bit_inc;
            phase_next      = PH_LOW;
            if (is_write) begin
              tick_count_next = nxt_bit ? short_t : long_t;
            end else begin
              tick_count_next = short_t;
            end
          end else begin
            tick_count_next = '0;
            phase_next      = PH_IDLE;
            done            = 1'b1;
          end
        end
        PH_WAIT: begin
          if (!expire) begin
            tick_count_next = tick_count - TickW'(1);
          end else if (operation == FN_RESET) begin
            tick_count_next = '0;
            if (!item.line_level) presence_seen_next = 1'b1;
            sample_count_next = CountW'(1);
            phase_next        = PH_SAMPLE;
          end else begin
            if (item.line_level) shift_data_next[bit_index] = 1'b1;
            phase_next      = PH_RECOV;
            tick_count_next = rrecov_t;
          end
        end
        PH_SAMPLE: begin
          if (sample_count < pres_limit) begin
            if (!item.line_level) presence_seen_next = 1'b1;
            sample_count_next = sample_count + CountW'(1);
          end else begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end else if (item.func <= FN_RBYTE) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        // Start a new command with its first slot.
        operation_next    = item.func;
        bit_index_next    = '0;
        sample_count_next = '0;
        phase_next        = PH_LOW;
        tick_count_next   = short_t;
        case (item.func)
          FN_RESET: begin
            presence_seen_next = 1'b0;
            shift_data_next    = '0;
            tick_count_next    = cfg.reset_low_ticks;
          end
          FN_WBIT: begin
            shift_data_next = {{(ByteW-1){1'b0}}, item.data_byte[0]};
            tick_count_next = item.data_byte[0] ? short_t : long_t;
          end
          FN_WBYTE: begin
            shift_data_next = item.data_byte;
            tick_count_next = item.data_byte[0] ? short_t : long_t;
          end
          default: shift_data_next = '0;
        endcase
      end
    end
  end

  // Status word taken from the state after this word.
  always_comb begin
    result.drive_low  = (phase_next == PH_LOW);
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = done;
    result.presence   = presence_seen_next;
    result.read_value = ((operation_next == FN_RBIT) || (operation_next == FN_RBYTE))
                        ? shift_data_next : '0;
    result.rejected   = rej;
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= '0;
      tick_count    <= '0;
      sample_count  <= '0;
      bit_index     <= '0;
      shift_data    <= '0;
      presence_seen <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      operation     <= operation_next;
      tick_count    <= tick_count_next;
      sample_count  <= sample_count_next;
      bit_index     <= bit_index_next;
      shift_data    <= shift_data_next;
      presence_seen <= presence_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/one_wire_bus_master_timing.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_timing
// 1-Wire master slot timing: commands start a sequence, tick words advance it.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_*       in         tuser: func; tdata: data_byte, line_level
//  m_*       out        tdata: drive_low, busy, done, presence, read_value,
//                       rejected (one status word per input word)
//  cfg_*     in         register index and value, one write per cycle
//
//  A word waits in the input register until the result register can take
//  its status word, so m_tvalid rises after the input and result registers;
//  one word per cycle is sustained while m_tready stays high.
//  Reset (rst, synchronous) empties both registers and restores defaults.
//  A stalled result holds; the input side stalls only when both stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_timing (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [owm_pkg::InDataW-1:0]   s_tdata,   // [7:0] data_byte, [8] line_level
  input  wire logic [owm_pkg::FuncW-1:0]     s_tuser,   // [2:0] func
  // Result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [owm_pkg::OutDataW-1:0]       m_tdata,   // [0] drive_low, [1] busy_res,
                                                        // [2] done_res, [3] presence,
                                                        // [11:4] read_value, [12] rejected
  // Configuration
  input  wire logic                          cfg_we,
  input  wire logic [owm_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [owm_pkg::CfgDataW-1:0]  cfg_wdata
);
  import owm_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t result;
  result_t out_word;

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The held word moves on when the result register is free or draining.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.func       <= s_tuser;
      in_item.data_byte  <= s_tdata[ByteW-1:0];
      in_item.line_level <= s_tdata[ByteW];
    end
  end

  owm_slot_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign m_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, out_word};

endmodule

`default_nettype wire

>>> sv/owm_checker.sv
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks on the result stream of the 1-Wire master timing block.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [owm_pkg::OutDataW-1:0] m_tdata
);
  import owm_pkg::*;

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The line is only driven during a command.
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("line driven while not busy");

  // Completion leaves the master idle and never comes with a rejection.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[12])
    else $error("done reported while busy or with rejection");

  // A rejected command only happens while a sequence is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[1])
    else $error("rejection reported while idle");

endmodule

bind one_wire_bus_master_timing owm_checker u_owm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
